@@ hw/rtl/sleep_timer_table_defines.svh @@
// assertion macros for the sleep timer table
`ifndef SLEEP_TIMER_TABLE_DEFINES_SVH
`define SLEEP_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/stt_pkg.sv @@
// shared types and constants for the sleep timer table
`timescale 1ns / 1ps

package stt_pkg;

   localparam int SLOTS_DEFAULT        = 32;
   localparam int PROCESS_BITS_DEFAULT = 8;
   localparam int REM_BITS             = 32;
   localparam int INTERVAL_BITS        = 10;
   localparam int OUT_PROC_BITS        = 8;

   localparam logic [REM_BITS-1:0]      USEC_PER_SEC   = 32'd1000000;
   localparam logic [REM_BITS-1:0]      USEC_PER_MS    = 32'd1000;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 10'd10;

   typedef enum logic [1:0] {
      MODE_TICK      = 2'd0,
      MODE_SLEEP_SEC = 2'd1,
      MODE_SLEEP_US  = 2'd2,
      MODE_UNUSED    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic {
      ALU_MUL,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [REM_BITS-1:0] a;
      logic [REM_BITS-1:0] b;
   } alu_ctl_type;

   typedef struct packed {
      logic [REM_BITS-1:0] value;
      logic                le;
   } alu_res_type;

endpackage

@@ hw/rtl/stt_req_if.sv @@
// request channel: tick or sleep beats into the table
`timescale 1ns / 1ps

interface stt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  process_id;
   logic [31:0] duration;

   modport source (output valid, mode, process_id, duration, input ready);
   modport sink (input valid, mode, process_id, duration, output ready);
endinterface

@@ hw/rtl/stt_rsp_if.sv @@
// response channel: wake and status beats out of the table
`timescale 1ns / 1ps

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic        woken_valid;
   logic [7:0]  woken_process;
   logic        table_full;
   logic [31:0] tick_total;
   logic        last_result;

   modport source (output valid, woken_valid, woken_process, table_full, tick_total,
                   last_result, input ready);
   modport sink (input valid, woken_valid, woken_process, table_full, tick_total,
                 last_result, output ready);
endinterface

@@ hw/rtl/stt_alu.sv @@
// shared multiply and compare-subtract unit
`timescale 1ns / 1ps

module stt_alu (
   input  stt_pkg::alu_ctl_type ctl,
   output stt_pkg::alu_res_type res
);

   logic [2*stt_pkg::REM_BITS-1:0] product;
   logic [stt_pkg::REM_BITS-1:0]   product_sat;

   assign product     = {{stt_pkg::REM_BITS{1'b0}}, ctl.a} * {{stt_pkg::REM_BITS{1'b0}}, ctl.b};
   assign product_sat = (product[2*stt_pkg::REM_BITS-1:stt_pkg::REM_BITS] != '0)
                        ? {stt_pkg::REM_BITS{1'b1}}
                        : product[stt_pkg::REM_BITS-1:0];

   always_comb begin
      res.le = (ctl.a <= ctl.b);
      unique case (ctl.op)
         stt_pkg::ALU_MUL: res.value = product_sat;
         stt_pkg::ALU_SUB: res.value = ctl.a - ctl.b;
         default:          res.value = ctl.a - ctl.b;
      endcase
   end

endmodule

@@ hw/rtl/stt_slot_mem.sv @@
// slot memory: one write port, one registered read port
`timescale 1ns / 1ps

module stt_slot_mem #(
   parameter int DEPTH = stt_pkg::SLOTS_DEFAULT,
   parameter int WIDTH = stt_pkg::REM_BITS + stt_pkg::PROCESS_BITS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sleep_timer_table.sv @@
// sleep timer table top level: sequencer, slot walk and response register
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------------
//   req     | in  | mode, process_id, duration
//   rsp     | out | woken_valid, woken_process, table_full, tick_total, last_result
//   csr     | in  | csr_wr_en, csr_wr_data (tick_interval_ms)
//
// sleep request: accept, scale/store, finish; unused mode skips the store
// tick: accept, a walk step per occupied slot through the shared compare-subtract unit and
//   the single slot memory read port, an end-of-walk step and a finish step
// req.ready is high only while idle; rsp stalls freeze the slot walk on a wake
// reset is synchronous and empties the table; no clearing pass is needed
`timescale 1ns / 1ps
`include "sleep_timer_table_defines.svh"

module sleep_timer_table #(
   parameter int SLOTS        = stt_pkg::SLOTS_DEFAULT,
   parameter int PROCESS_BITS = stt_pkg::PROCESS_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [stt_pkg::INTERVAL_BITS-1:0]  csr_wr_data,
   stt_req_if.sink                            req,
   stt_rsp_if.source                          rsp
);

   localparam int AW      = $clog2(SLOTS);
   localparam int CW      = $clog2(SLOTS + 1);
   localparam int WW      = stt_pkg::REM_BITS + PROCESS_BITS;
   localparam int PB_KEEP = (PROCESS_BITS < 8) ? PROCESS_BITS : 8;

   stt_pkg::state_type state_ff, state_in;
   stt_pkg::mode_type  mode_ff, mode_in;

   logic [stt_pkg::INTERVAL_BITS-1:0] interval_ff;
   logic [31:0]                       tick_ff, tick_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     keep_ff, keep_in;
   logic [CW-1:0]                     idx_next;
   logic [stt_pkg::REM_BITS-1:0]      amount_ff, amount_in;
   logic [stt_pkg::REM_BITS-1:0]      dur_ff, dur_in;
   logic [PROCESS_BITS-1:0]           pid_ff, pid_in;
   logic                              full_ff, full_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [PROCESS_BITS-1:0]           pend_proc_ff, pend_proc_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_woken_valid_ff, rsp_woken_valid_in;
   logic [stt_pkg::OUT_PROC_BITS-1:0]   rsp_proc_ff, rsp_proc_in;
   logic                                rsp_full_ff, rsp_full_in;
   logic [31:0]                         rsp_tick_ff, rsp_tick_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                out_free;

   stt_pkg::alu_ctl_type alu_ctl;
   stt_pkg::alu_res_type alu_res;

   logic                         mem_wr_en;
   logic [AW-1:0]                mem_wr_addr;
   logic [WW-1:0]                mem_wr_data;
   logic [AW-1:0]                mem_rd_addr;
   logic [WW-1:0]                mem_rd_data;
   logic [stt_pkg::REM_BITS-1:0] rd_rem;
   logic [PROCESS_BITS-1:0]      rd_proc;
   logic [stt_pkg::REM_BITS-1:0] scaled_us;

   stt_alu u_alu (
      .ctl (alu_ctl),
      .res (alu_res)
   );

   stt_slot_mem #(
      .DEPTH (SLOTS),
      .WIDTH (WW),
      .AW    (AW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_rem   = mem_rd_data[WW-1:PROCESS_BITS];
   assign rd_proc  = mem_rd_data[PROCESS_BITS-1:0];
   assign idx_next = idx_ff + CW'(1);
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign req.ready         = (state_ff == stt_pkg::ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.woken_valid   = rsp_woken_valid_ff;
   assign rsp.woken_process = rsp_proc_ff;
   assign rsp.table_full    = rsp_full_ff;
   assign rsp.tick_total    = rsp_tick_ff;
   assign rsp.last_result   = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stt_pkg::ST_IDLE;
         interval_ff   <= stt_pkg::INTERVAL_RESET;
         tick_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         keep_ff       <= '0;
         full_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         keep_ff       <= keep_in;
         full_ff       <= full_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff            <= mode_in;
      amount_ff          <= amount_in;
      dur_ff             <= dur_in;
      pid_ff             <= pid_in;
      pend_proc_ff       <= pend_proc_in;
      rsp_woken_valid_ff <= rsp_woken_valid_in;
      rsp_proc_ff        <= rsp_proc_in;
      rsp_full_ff        <= rsp_full_in;
      rsp_tick_ff        <= rsp_tick_in;
      rsp_last_ff        <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tick_in       = tick_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      keep_in       = keep_ff;
      amount_in     = amount_ff;
      dur_in        = dur_ff;
      pid_in        = pid_ff;
      full_in       = full_ff;
      pend_valid_in = pend_valid_ff;
      pend_proc_in  = pend_proc_ff;

      rsp_valid_in       = rsp_valid_ff && !rsp.ready;
      rsp_woken_valid_in = rsp_woken_valid_ff;
      rsp_proc_in        = rsp_proc_ff;
      rsp_full_in        = rsp_full_ff;
      rsp_tick_in        = rsp_tick_ff;
      rsp_last_in        = rsp_last_ff;

      alu_ctl.op  = stt_pkg::ALU_SUB;
      alu_ctl.a   = rd_rem;
      alu_ctl.b   = amount_ff;
      scaled_us   = dur_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = keep_ff[AW-1:0];
      mem_wr_data = {alu_res.value, rd_proc};
      mem_rd_addr = idx_ff[AW-1:0];

      unique case (state_ff)
         stt_pkg::ST_IDLE: begin
            alu_ctl.op  = stt_pkg::ALU_MUL;
            alu_ctl.a   = stt_pkg::REM_BITS'(interval_ff);
            alu_ctl.b   = stt_pkg::USEC_PER_MS;
            mem_rd_addr = '0;
            if (req.valid) begin
               mode_in       = stt_pkg::mode_type'(req.mode);
               dur_in        = req.duration;
               pid_in        = PROCESS_BITS'(req.process_id[PB_KEEP-1:0]);
               full_in       = 1'b0;
               pend_valid_in = 1'b0;
               unique case (stt_pkg::mode_type'(req.mode))
                  stt_pkg::MODE_TICK: begin
                     tick_in   = tick_ff + 32'd1;
                     amount_in = alu_res.value;
                     idx_in    = '0;
                     keep_in   = '0;
                     state_in  = stt_pkg::ST_SCAN;
                  end
                  stt_pkg::MODE_SLEEP_SEC,
                  stt_pkg::MODE_SLEEP_US: state_in = stt_pkg::ST_SCALE;
                  stt_pkg::MODE_UNUSED:   state_in = stt_pkg::ST_FINISH;
                  default:                state_in = stt_pkg::ST_FINISH;
               endcase
            end
         end

         stt_pkg::ST_SCALE: begin
            alu_ctl.op = stt_pkg::ALU_MUL;
            alu_ctl.a  = dur_ff;
            alu_ctl.b  = stt_pkg::USEC_PER_SEC;
            if (mode_ff == stt_pkg::MODE_SLEEP_SEC) begin
               scaled_us = alu_res.value;
            end
            if (count_ff == CW'(SLOTS)) begin
               full_in = 1'b1;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = count_ff[AW-1:0];
               mem_wr_data = {scaled_us, pid_ff};
               count_in    = count_ff + CW'(1);
            end
            state_in = stt_pkg::ST_FINISH;
         end

         stt_pkg::ST_SCAN: begin
            if (idx_ff == count_ff) begin
               count_in = keep_ff;
               state_in = stt_pkg::ST_FINISH;
            end else if (alu_res.le) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_woken_valid_in = 1'b1;
                     rsp_proc_in        = stt_pkg::OUT_PROC_BITS'(pend_proc_ff);
                     rsp_full_in        = 1'b0;
                     rsp_tick_in        = tick_ff;
                     rsp_last_in        = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_proc_in  = rd_proc;
                  idx_in        = idx_next;
                  mem_rd_addr   = idx_next[AW-1:0];
               end
            end else begin
               mem_wr_en   = 1'b1;
               keep_in     = keep_ff + CW'(1);
               idx_in      = idx_next;
               mem_rd_addr = idx_next[AW-1:0];
            end
         end

         stt_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_woken_valid_in = pend_valid_ff;
               rsp_proc_in        = pend_valid_ff
                                    ? stt_pkg::OUT_PROC_BITS'(pend_proc_ff)
                                    : '0;
               rsp_full_in        = full_ff;
               rsp_tick_in        = tick_ff;
               rsp_last_in        = 1'b1;
               state_in           = stt_pkg::ST_IDLE;
            end
         end

         default: state_in = stt_pkg::ST_IDLE;
      endcase
   end

   `STT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(SLOTS), "entry count beyond table depth")
   `STT_ASSERT_NOW(a_keep_behind, clock, reset, state_ff == stt_pkg::ST_SCAN, keep_ff <= idx_ff && idx_ff <= count_ff, "compaction pointer ahead of walk")
   `STT_ASSERT_NOW(a_write_state, clock, reset, mem_wr_en, state_ff == stt_pkg::ST_SCAN || state_ff == stt_pkg::ST_SCALE, "slot write outside scale or scan")
   `STT_ASSERT_NEXT(a_tick_hold, clock, reset, !reset && !(req.valid && req.ready && req.mode == stt_pkg::MODE_TICK), $stable(tick_ff), "tick counter moved without a tick beat")

endmodule
